// File: rtl/core/tfs_pkg.sv
// ----------------------------------------------------------------------------
// tfs_pkg: shared constants for the triangle flat split block
// Default coordinate width and the fixed width of the color index.
// ----------------------------------------------------------------------------
package tfs_pkg;

	// default coordinate width in bits
	localparam int COORD_BITS_DEF = 10;

	// width of the color index
	localparam int FILL_BITS = 8;

endpackage
// ----------------------------------------------------------------------------

// File: rtl/core/tfs_sort.sv
// ----------------------------------------------------------------------------
// tfs_sort: vertex role assignment
// Orders the three vertices into top, middle and bottom, or applies the fixed
// roles of an already flat triangle. The result is registered.
// ----------------------------------------------------------------------------
module tfs_sort #(
	parameter int COORD_BITS = tfs_pkg::COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_vld,
	input  logic [COORD_BITS-1:0] x1,
	input  logic [COORD_BITS-1:0] y1,
	input  logic [COORD_BITS-1:0] x2,
	input  logic [COORD_BITS-1:0] y2,
	input  logic [COORD_BITS-1:0] x3,
	input  logic [COORD_BITS-1:0] y3,
	output logic                  vld_s1,
	output logic [COORD_BITS-1:0] tx_s1,
	output logic [COORD_BITS-1:0] ty_s1,
	output logic [COORD_BITS-1:0] bx_s1,
	output logic [COORD_BITS-1:0] by_s1,
	output logic [COORD_BITS-1:0] mx_s1,
	output logic [COORD_BITS-1:0] my_s1,
	output logic [COORD_BITS-1:0] sx_s1,
	output logic                  flat_s1
);

	logic [COORD_BITS-1:0] tx, ty, bx, by, mx, my, sx;
	logic                  flat;

	// role selection, checks in fixed order
	always_comb begin
		tx   = x3;
		ty   = y3;
		bx   = x3;
		by   = y3;
		mx   = x3;
		my   = y3;
		sx   = x3;
		flat = 1'b1;
		priority if (y1 == y2) begin
			mx = x1;
			my = y1;
			sx = x2;
			if (y3 >= y2) begin
				bx = x3; by = y3; tx = x2; ty = y2;
			end else begin
				tx = x3; ty = y3; bx = x2; by = y2;
			end
		end else if (y2 == y3) begin
			mx = x2;
			my = y2;
			sx = x3;
			if (y1 > y2) begin
				bx = x1; by = y1; tx = x3; ty = y3;
			end else begin
				tx = x1; ty = y1; bx = x3; by = y3;
			end
		end else if (y1 == y3) begin
			mx = x1;
			my = y1;
			sx = x3;
			if (y2 > y1) begin
				bx = x2; by = y2; tx = x3; ty = y3;
			end else begin
				tx = x2; ty = y2; bx = x3; by = y3;
			end
		end else begin
			// all y distinct
			flat = 1'b0;
			priority if (y1 < y2 && y1 < y3) begin
				tx = x1; ty = y1;
			end else if (y2 < y1 && y2 < y3) begin
				tx = x2; ty = y2;
			end else begin
				tx = x3; ty = y3;
			end
			priority if (y1 > y2 && y1 > y3) begin
				bx = x1; by = y1;
			end else if (y2 > y1 && y2 > y3) begin
				bx = x2; by = y2;
			end else begin
				bx = x3; by = y3;
			end
			priority if ((y1 > y2 && y1 < y3) || (y1 < y2 && y1 > y3)) begin
				mx = x1; my = y1;
			end else if ((y2 > y1 && y2 < y3) || (y2 < y1 && y2 > y3)) begin
				mx = x2; my = y2;
			end else begin
				mx = x3; my = y3;
			end
		end
	end

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		tx_s1   <= tx;
		ty_s1   <= ty;
		bx_s1   <= bx;
		by_s1   <= by;
		mx_s1   <= mx;
		my_s1   <= my;
		sx_s1   <= sx;
		flat_s1 <= flat;
	end

endmodule
// ----------------------------------------------------------------------------

// File: rtl/core/tfs_div_cell.sv
// ----------------------------------------------------------------------------
// tfs_div_cell: one restoring division step
// Takes one numerator bit into the partial remainder, develops one quotient
// bit and hands everything to the next cell, together with the word's
// sideband.
// ----------------------------------------------------------------------------
module tfs_div_cell #(
	parameter int COORD_BITS = tfs_pkg::COORD_BITS_DEF,
	parameter int SIDE_W     = 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  vld_i,
	input  logic [COORD_BITS-1:0] rem_i,
	input  logic [COORD_BITS-1:0] num_i,
	input  logic [COORD_BITS-1:0] quo_i,
	input  logic [COORD_BITS-1:0] den_i,
	input  logic [SIDE_W-1:0]     side_i,
	output logic                  vld_q,
	output logic [COORD_BITS-1:0] rem_q,
	output logic [COORD_BITS-1:0] num_q,
	output logic [COORD_BITS-1:0] quo_q,
	output logic [COORD_BITS-1:0] den_q,
	output logic [SIDE_W-1:0]     side_q
);

	logic [COORD_BITS+1:0] trial;
	logic                  fits;

	// trial subtract of the divisor from the shifted remainder
	assign trial = {1'b0, rem_i, num_i[COORD_BITS-1]} - {2'b00, den_i};
	assign fits  = ~trial[COORD_BITS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		rem_q  <= fits ? trial[COORD_BITS-1:0] : {rem_i[COORD_BITS-2:0], num_i[COORD_BITS-1]};
		num_q  <= {num_i[COORD_BITS-2:0], 1'b0};
		quo_q  <= {quo_i[COORD_BITS-2:0], fits};
		den_q  <= den_i;
		side_q <= side_i;
	end

endmodule
// ----------------------------------------------------------------------------

// File: rtl/core/triangle_flat_split.sv
// ----------------------------------------------------------------------------
// triangle_flat_split: split a triangle into flat-bottom and flat-top parts
// Sorts the vertices, finds the split x on the long edge with exact floor
// division, and sends two triangle words per input word.
// ----------------------------------------------------------------------------
//
//  channel  | handshake          | fields
//  ---------+--------------------+-------------------------------------------
//  input    | start / busy       | ax ay bx by cx cy shade
//  result   | strobe (one cycle) | apex_x apex_y mid_x mid_y split_x split_y
//           |                    | fill last
//
//  busy is set in the cycle after each accepted word, since each word
//  yields two result words on one channel. Each accepted word passes the
//  sort register, the stage 2 register, a chain of COORD_BITS divider step
//  cells (one quotient bit per cell) and the output register; the second
//  result word follows the first in the next cycle.
//  Reset clears all valid bits; no word is in flight after reset.
//  The receiver cannot stall; results are never held.
//
// ----------------------------------------------------------------------------
module triangle_flat_split #(
	parameter int COORD_BITS = tfs_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [COORD_BITS-1:0]        ax,
	input  logic [COORD_BITS-1:0]        ay,
	input  logic [COORD_BITS-1:0]        bx,
	input  logic [COORD_BITS-1:0]        by,
	input  logic [COORD_BITS-1:0]        cx,
	input  logic [COORD_BITS-1:0]        cy,
	input  logic [tfs_pkg::FILL_BITS-1:0] shade,
	output logic                         strobe,
	output logic [COORD_BITS-1:0]        apex_x,
	output logic [COORD_BITS-1:0]        apex_y,
	output logic [COORD_BITS-1:0]        mid_x,
	output logic [COORD_BITS-1:0]        mid_y,
	output logic [COORD_BITS-1:0]        split_x,
	output logic [COORD_BITS-1:0]        split_y,
	output logic [tfs_pkg::FILL_BITS-1:0] fill,
	output logic                         last
);

	localparam int W = COORD_BITS;

	// data that rides alongside the divider
	typedef struct packed {
		logic [W-1:0]                  tx;
		logic [W-1:0]                  ty;
		logic [W-1:0]                  bx;
		logic [W-1:0]                  by;
		logic [W-1:0]                  mx;
		logic [W-1:0]                  my;
		logic [W-1:0]                  sx;
		logic                          flat;
		logic                          neg;
		logic [tfs_pkg::FILL_BITS-1:0] fill;
	} side_t;

	localparam int SIDE_W = $bits(side_t);

	logic accept;
	logic busy_q;

	// input handshake: no word is taken while busy is high
	assign accept = start & ~busy_q;
	assign busy   = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else begin
			busy_q <= accept;
		end
	end

	// stage 1: vertex roles
	logic                         vld_s1, flat_s1;
	logic [W-1:0]                 tx_s1, ty_s1, bx_s1, by_s1, mx_s1, my_s1, sx_s1;
	logic [tfs_pkg::FILL_BITS-1:0] fill_s1;

	tfs_sort #(.COORD_BITS(W)) u_sort (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (accept),
		.x1      (ax),
		.y1      (ay),
		.x2      (bx),
		.y2      (by),
		.x3      (cx),
		.y3      (cy),
		.vld_s1  (vld_s1),
		.tx_s1   (tx_s1),
		.ty_s1   (ty_s1),
		.bx_s1   (bx_s1),
		.by_s1   (by_s1),
		.mx_s1   (mx_s1),
		.my_s1   (my_s1),
		.sx_s1   (sx_s1),
		.flat_s1 (flat_s1)
	);

	always_ff @(posedge clk) begin
		fill_s1 <= shade;
	end

	// stage 2: numerator magnitude, sign and divisor
	logic           neg;
	logic [W-1:0]   dx_mag;
	logic [W-1:0]   dy_num;
	logic           vld_s2;
	logic [2*W-1:0] prod_s2;
	logic [W-1:0]   den_s2;
	side_t          side_s2;

	assign neg    = bx_s1 < tx_s1;
	assign dx_mag = neg ? (tx_s1 - bx_s1) : (bx_s1 - tx_s1);
	assign dy_num = my_s1 - ty_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2      <= {{W{1'b0}}, dy_num} * {{W{1'b0}}, dx_mag};
		den_s2       <= by_s1 - ty_s1;
		side_s2.tx   <= tx_s1;
		side_s2.ty   <= ty_s1;
		side_s2.bx   <= bx_s1;
		side_s2.by   <= by_s1;
		side_s2.mx   <= mx_s1;
		side_s2.my   <= my_s1;
		side_s2.sx   <= sx_s1;
		side_s2.flat <= flat_s1;
		side_s2.neg  <= neg;
		side_s2.fill <= fill_s1;
	end

	// divider chain: for a triangle that is not flat, the high half of the product never reaches the divisor
	logic              vld_c  [0:W];
	logic [W-1:0]      rem_c  [0:W];
	logic [W-1:0]      num_c  [0:W];
	logic [W-1:0]      quo_c  [0:W];
	logic [W-1:0]      den_c  [0:W];
	logic [SIDE_W-1:0] side_c [0:W];

	assign vld_c[0]  = vld_s2;
	assign rem_c[0]  = prod_s2[2*W-1:W];
	assign num_c[0]  = prod_s2[W-1:0];
	assign quo_c[0]  = '0;
	assign den_c[0]  = den_s2;
	assign side_c[0] = side_s2;

	for (genvar k = 0; k < W; k++) begin : g_cell
		tfs_div_cell #(.COORD_BITS(W), .SIDE_W(SIDE_W)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.vld_i  (vld_c[k]),
			.rem_i  (rem_c[k]),
			.num_i  (num_c[k]),
			.quo_i  (quo_c[k]),
			.den_i  (den_c[k]),
			.side_i (side_c[k]),
			.vld_q  (vld_c[k+1]),
			.rem_q  (rem_c[k+1]),
			.num_q  (num_c[k+1]),
			.quo_q  (quo_c[k+1]),
			.den_q  (den_c[k+1]),
			.side_q (side_c[k+1])
		);
	end

	// floor correction and split x
	side_t        side_o;
	logic [W-1:0] sx_div;
	logic [W-1:0] sx_fin;

	assign side_o = side_c[W];
	assign sx_div = side_o.neg
		? (side_o.tx - quo_c[W] - {{(W-1){1'b0}}, (rem_c[W] != '0)})
		: (side_o.tx + quo_c[W]);
	assign sx_fin = side_o.flat ? side_o.sx : sx_div;

	// result word sequencing: first word bottom apex, second word top apex
	logic                          emit_q, last_q;
	logic [W-1:0]                  tx_q, ty_q, bx_q, by_q, mx_q, my_q, sx_q;
	logic [tfs_pkg::FILL_BITS-1:0] fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			priority if (vld_c[W]) begin
				emit_q <= 1'b1;
				last_q <= 1'b0;
			end else if (emit_q && !last_q) begin
				last_q <= 1'b1;
			end else begin
				emit_q <= 1'b0;
				last_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld_c[W]) begin
			tx_q   <= side_o.tx;
			ty_q   <= side_o.ty;
			bx_q   <= side_o.bx;
			by_q   <= side_o.by;
			mx_q   <= side_o.mx;
			my_q   <= side_o.my;
			sx_q   <= sx_fin;
			fill_q <= side_o.fill;
		end
	end

	assign strobe  = emit_q;
	assign last    = last_q;
	assign apex_x  = last_q ? tx_q : bx_q;
	assign apex_y  = last_q ? ty_q : by_q;
	assign mid_x   = mx_q;
	assign mid_y   = my_q;
	assign split_x = sx_q;
	assign split_y = my_q;
	assign fill    = fill_q;

endmodule
// ----------------------------------------------------------------------------

// File: rtl/core/tfs_checker.sv
// ----------------------------------------------------------------------------
// tfs_checker: port-level checks for the triangle flat split block
// Watches the result word pairing and the input throttle.
// ----------------------------------------------------------------------------
module tfs_checker #(
	parameter int COORD_BITS = tfs_pkg::COORD_BITS_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          strobe,
	input logic [COORD_BITS-1:0]         mid_x,
	input logic [COORD_BITS-1:0]         mid_y,
	input logic [COORD_BITS-1:0]         split_x,
	input logic [COORD_BITS-1:0]         split_y,
	input logic [tfs_pkg::FILL_BITS-1:0] fill,
	input logic                          last
);

	// a first word is always followed by its second word
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe && last)
		else $error("first result word not followed by second");

	// a second word is never repeated
	a_no_double: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !(strobe && last))
		else $error("second result word repeated");

	// both words of a pair share middle, split x and fill
	a_same_tri: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> $stable(mid_x) && $stable(mid_y) && $stable(split_x)
			&& $stable(fill))
		else $error("result pair does not describe one triangle");

	// the split vertex sits at the middle y
	a_split_y: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> split_y == mid_y)
		else $error("split y differs from middle y");

	// an accepted word blocks the next cycle
	a_throttle: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("input accepted on consecutive cycles");

endmodule

bind triangle_flat_split tfs_checker #(.COORD_BITS(COORD_BITS)) u_tfs_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.strobe  (strobe),
	.mid_x   (mid_x),
	.mid_y   (mid_y),
	.split_x (split_x),
	.split_y (split_y),
	.fill    (fill),
	.last    (last)
);
// ----------------------------------------------------------------------------

// File: tb/sv/triangle_flat_split_test.sv
// ----------------------------------------------------------------------------
// triangle_flat_split_test: self-checking bench for triangle_flat_split
// Drives triangle words over the start/busy handshake in random bursts, runs
// a short directed table and then random triangles, and checks every result
// word in order, field by field, against a typed pair or an in-bench splitter.
// ----------------------------------------------------------------------------
module triangle_flat_split_test;

	localparam int CB = tfs_pkg::COORD_BITS_DEF;
	localparam int FB = tfs_pkg::FILL_BITS;

	localparam int RANDOM_WORDS = 1880;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int SETTLE       = CB + 8;
	localparam int REPORT_MAX   = 10;

	typedef logic [CB-1:0] coord_t;

	// one input word: three vertices and a color index
	typedef struct packed {
		coord_t          ax, ay, bx, by, cx, cy;
		logic [FB-1:0]   shade;
	} tri_in_t;

	// one result word: a flat triangle
	typedef struct packed {
		coord_t          apex_x, apex_y, mid_x, mid_y, split_x, split_y;
		logic [FB-1:0]   fill;
		logic            last;
	} flat_tri_t;

	// directed row: input word, with the result pair typed in where obvious
	typedef struct packed {
		tri_in_t         word;
		logic            typed;
		flat_tri_t       lower;
		flat_tri_t       upper;
	} dir_row_t;

	localparam flat_tri_t NO_TRI = '0;
	localparam int N_DIRECTED = 23;

	localparam dir_row_t DIRECTED [N_DIRECTED] = '{
		// all zero
		'{'{0, 0, 0, 0, 0, 0, 0}, 1'b1,
			'{0, 0, 0, 0, 0, 0, 0, 1'b0}, '{0, 0, 0, 0, 0, 0, 0, 1'b1}},
		// all max, every y equal
		'{'{1023, 1023, 1023, 1023, 1023, 1023, 255}, 1'b1,
			'{1023, 1023, 1023, 1023, 1023, 1023, 255, 1'b0},
			'{1023, 1023, 1023, 1023, 1023, 1023, 255, 1'b1}},
		// first/second flat, third above the pair
		'{'{100, 500, 200, 500, 300, 10, 8'h5a}, 1'b1,
			'{200, 500, 100, 500, 200, 500, 8'h5a, 1'b0},
			'{300, 10, 100, 500, 200, 500, 8'h5a, 1'b1}},
		// first/second flat, third below
		'{'{5, 300, 900, 300, 450, 1000, 1}, 1'b0, NO_TRI, NO_TRI},
		// second/third flat, first below then above
		'{'{10, 900, 20, 100, 30, 100, 2}, 1'b0, NO_TRI, NO_TRI},
		'{'{10, 50, 20, 100, 30, 100, 3}, 1'b0, NO_TRI, NO_TRI},
		// first/third flat, second below then above
		'{'{1023, 400, 0, 1023, 512, 400, 4}, 1'b0, NO_TRI, NO_TRI},
		'{'{1023, 400, 0, 0, 512, 400, 5}, 1'b0, NO_TRI, NO_TRI},
		// all three y equal, mid range
		'{'{7, 512, 900, 512, 33, 512, 6}, 1'b0, NO_TRI, NO_TRI},
		// vertical long edge
		'{'{300, 0, 0, 500, 300, 1000, 7}, 1'b0, NO_TRI, NO_TRI},
		// full positive slope
		'{'{0, 0, 1023, 1023, 0, 512, 8'h01}, 1'b0, NO_TRI, NO_TRI},
		// negative slope, inexact quotient rounds down
		'{'{1023, 0, 0, 1022, 500, 1, 8'h80}, 1'b0, NO_TRI, NO_TRI},
		// negative slope, exact quotient
		'{'{1023, 0, 0, 1023, 7, 1, 8'h40}, 1'b0, NO_TRI, NO_TRI},
		// every ordering of distinct y values
		'{'{10, 100, 500, 600, 900, 900, 8'h11}, 1'b0, NO_TRI, NO_TRI},
		'{'{10, 100, 900, 900, 500, 600, 8'h22}, 1'b0, NO_TRI, NO_TRI},
		'{'{500, 600, 10, 100, 900, 900, 8'h33}, 1'b0, NO_TRI, NO_TRI},
		'{'{900, 900, 10, 100, 500, 600, 8'h44}, 1'b0, NO_TRI, NO_TRI},
		'{'{500, 600, 900, 900, 10, 100, 8'h66}, 1'b0, NO_TRI, NO_TRI},
		'{'{900, 900, 500, 600, 10, 100, 8'h77}, 1'b0, NO_TRI, NO_TRI},
		// coordinate extremes and neighboring y values
		'{'{1023, 1, 0, 1022, 1023, 1023, 8'hff}, 1'b0, NO_TRI, NO_TRI},
		'{'{0, 511, 1023, 512, 512, 513, 8'h55}, 1'b0, NO_TRI, NO_TRI},
		'{'{1023, 1022, 0, 1023, 512, 0, 8'haa}, 1'b0, NO_TRI, NO_TRI},
		'{'{0, 1023, 1023, 0, 1, 1, 8'h0f}, 1'b0, NO_TRI, NO_TRI}
	};

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	coord_t              ax, ay, bx, by, cx, cy;
	logic [FB-1:0]       shade;
	logic                strobe;
	coord_t              apex_x, apex_y, mid_x, mid_y, split_x, split_y;
	logic [FB-1:0]       fill;
	logic                last;

	flat_tri_t           flat_tris_due [$];
	int                  mismatches;
	int                  cycle_count;
	int                  burst_left;

	triangle_flat_split #(.COORD_BITS(CB)) uut (.*);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// splits one triangle into its bottom/middle/split and top/middle/split words
	function automatic void split_triangle(input tri_in_t w, output flat_tri_t lower,
			output flat_tri_t upper);
		longint x1, y1, x2, y2, x3, y3;
		longint tx, ty, lx, ly, mx, my, sx, sy, num, den, q;
		x1 = w.ax; y1 = w.ay;
		x2 = w.bx; y2 = w.by;
		x3 = w.cx; y3 = w.cy;
		if (y1 == y2) begin
			mx = x1; my = y1; sx = x2; sy = y2;
			if (y3 >= y2) begin
				lx = x3; ly = y3; tx = sx; ty = sy;
			end else begin
				tx = x3; ty = y3; lx = sx; ly = sy;
			end
		end else if (y2 == y3) begin
			mx = x2; my = y2; sx = x3; sy = y3;
			if (y1 > y2) begin
				lx = x1; ly = y1; tx = sx; ty = sy;
			end else begin
				tx = x1; ty = y1; lx = sx; ly = sy;
			end
		end else if (y1 == y3) begin
			mx = x1; my = y1; sx = x3; sy = y3;
			if (y2 > y1) begin
				lx = x2; ly = y2; tx = sx; ty = sy;
			end else begin
				tx = x2; ty = y2; lx = sx; ly = sy;
			end
		end else begin
			// distinct y: sort, then floor-divide along the long edge
			if (y1 < y2 && y1 < y3) begin
				tx = x1; ty = y1;
			end else if (y2 < y1 && y2 < y3) begin
				tx = x2; ty = y2;
			end else begin
				tx = x3; ty = y3;
			end
			if (y1 > y2 && y1 > y3) begin
				lx = x1; ly = y1;
			end else if (y2 > y1 && y2 > y3) begin
				lx = x2; ly = y2;
			end else begin
				lx = x3; ly = y3;
			end
			if ((y1 > y2 && y1 < y3) || (y1 < y2 && y1 > y3)) begin
				mx = x1; my = y1;
			end else if ((y2 > y1 && y2 < y3) || (y2 < y1 && y2 > y3)) begin
				mx = x2; my = y2;
			end else begin
				mx = x3; my = y3;
			end
			num = (my - ty) * (lx - tx);
			den = ly - ty;
			q = num / den;
			if ((num % den) != 0 && num < 0)
				q = q - 1;
			sy = my;
			sx = tx + q;
		end
		lower = '{coord_t'(lx), coord_t'(ly), coord_t'(mx), coord_t'(my),
			coord_t'(sx), coord_t'(sy), w.shade, 1'b0};
		upper = '{coord_t'(tx), coord_t'(ty), coord_t'(mx), coord_t'(my),
			coord_t'(sx), coord_t'(sy), w.shade, 1'b1};
	endfunction

	// coordinate near the ends of the range, or anywhere
	function automatic coord_t rim_coord();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return coord_t'(1);
			2: return coord_t'((1 << CB) - 2);
			3: return coord_t'((1 << CB) - 1);
			default: return coord_t'($urandom);
		endcase
	endfunction

	// random triangle: uniform about half the time, else flat pairs, close y or extremes
	function automatic tri_in_t rand_word();
		tri_in_t w;
		int      kind;
		int      base;
		w.ax = coord_t'($urandom); w.ay = coord_t'($urandom);
		w.bx = coord_t'($urandom); w.by = coord_t'($urandom);
		w.cx = coord_t'($urandom); w.cy = coord_t'($urandom);
		w.shade = FB'($urandom);
		kind = $urandom_range(0, 99);
		if (kind < 25) begin
			case ($urandom_range(0, 2))
				0: w.by = w.ay;
				1: w.cy = w.by;
				default: w.cy = w.ay;
			endcase
			if ($urandom_range(0, 9) == 0) begin
				w.by = w.ay;
				w.cy = w.ay;
			end
		end else if (kind < 40) begin
			base = $urandom_range(0, (1 << CB) - 4);
			w.ay = coord_t'(base + $urandom_range(0, 3));
			w.by = coord_t'(base + $urandom_range(0, 3));
			w.cy = coord_t'(base + $urandom_range(0, 3));
		end else if (kind < 52) begin
			w.ax = rim_coord(); w.ay = rim_coord();
			w.bx = rim_coord(); w.by = rim_coord();
			w.cx = rim_coord(); w.cy = rim_coord();
		end
		return w;
	endfunction

	// present one word, wait for the accept, queue its results, then maybe idle
	task automatic send_word(input tri_in_t w, input logic typed, input flat_tri_t lo,
			input flat_tri_t hi);
		flat_tri_t p_lo;
		flat_tri_t p_hi;
		int        gap;
		ax <= w.ax; ay <= w.ay;
		bx <= w.bx; by <= w.by;
		cx <= w.cx; cy <= w.cy;
		shade <= w.shade;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		if (typed) begin
			p_lo = lo;
			p_hi = hi;
		end else begin
			split_triangle(w, p_lo, p_hi);
		end
		flat_tris_due.push_back(p_lo);
		flat_tris_due.push_back(p_hi);
		// bursts with random gaps; junk on the inputs while start is low
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 25) : $urandom_range(1, 3);
			start <= 1'b0;
			ax <= coord_t'($urandom); ay <= coord_t'($urandom);
			by <= coord_t'($urandom); cy <= coord_t'($urandom);
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
				: $urandom_range(0, 10);
		end
	endtask

	// hold off until every queued result has come out
	task automatic drain();
		start <= 1'b0;
		while (flat_tris_due.size() != 0) @(posedge clk);
	endtask

	// stimulus
	initial begin
		start = 1'b0;
		arst_n = 1'b0;
		ax = '0; ay = '0; bx = '0; by = '0; cx = '0; cy = '0;
		shade = '0;
		burst_left = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			send_word(DIRECTED[i].word, DIRECTED[i].typed, DIRECTED[i].lower,
				DIRECTED[i].upper);
		drain();
		@(posedge clk);

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i == RANDOM_WORDS / 2) begin
				drain();
				@(posedge clk);
			end
			send_word(rand_word(), 1'b0, NO_TRI, NO_TRI);
		end

		drain();
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	task automatic report(input string what, input flat_tri_t want, input flat_tri_t got,
			input logic show_want);
		mismatches++;
		if (mismatches <= REPORT_MAX) begin
			$display("%0t: %s", $realtime, what);
			if (show_want)
				$display("  exp apex=(%0d,%0d) mid=(%0d,%0d) split=(%0d,%0d) fill=%0d last=%0d",
					want.apex_x, want.apex_y, want.mid_x, want.mid_y,
					want.split_x, want.split_y, want.fill, want.last);
			$display("  got apex=(%0d,%0d) mid=(%0d,%0d) split=(%0d,%0d) fill=%0d last=%0d",
				got.apex_x, got.apex_y, got.mid_x, got.mid_y,
				got.split_x, got.split_y, got.fill, got.last);
		end
	endtask

	// result checker: every strobed word against the oldest queued one
	always @(posedge clk) begin
		flat_tri_t got;
		flat_tri_t want;
		if (arst_n && strobe === 1'b1) begin
			got = '{apex_x, apex_y, mid_x, mid_y, split_x, split_y, fill, last};
			if (flat_tris_due.size() == 0) begin
				report("result word with none expected", NO_TRI, got, 1'b0);
			end else begin
				want = flat_tris_due.pop_front();
				if (got.apex_x !== want.apex_x || got.apex_y !== want.apex_y ||
						got.mid_x !== want.mid_x || got.mid_y !== want.mid_y ||
						got.split_x !== want.split_x || got.split_y !== want.split_y ||
						got.fill !== want.fill || got.last !== want.last)
					report("result word mismatch", want, got, 1'b1);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

endmodule
// ----------------------------------------------------------------------------
